// ===== src/fptw_pkg.sv =====
// Package for the four-level page table walker.
// Holds sizes, field widths, opcodes and the controller/datapath command types.
// No dependencies.
package fptw_pkg;

  localparam int TABLE_WORDS = 4096;
  localparam int MEM_AW      = $clog2(TABLE_WORDS);

  localparam int PA_W    = 52;
  localparam int VA_W    = 48;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;
  localparam int PAGE_SH = 12;

  localparam int ENT_PRESENT = 0;
  localparam int ENT_LARGE   = 7;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Table level being read; selects the virtual address slice.
  typedef enum logic [1:0] {
    LVL_4,
    LVL_3,
    LVL_2,
    LVL_1
  } lvl_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_FAULT,
    RES_1G,
    RES_2M,
    RES_4K
  } res_kind_t;

  typedef struct packed {
    logic      mem_we;
    logic      clr_sel;
    logic      mem_re;
    logic      from_root;
    lvl_t      lvl;
    logic      load_item;
    logic      res_load;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic present;
    logic page_size;
    logic out_busy;
    logic clr_last;
    logic req_op;
  } dp_status_t;

endpackage

// ===== src/fptw_if.sv =====
// Valid/ready channel interfaces for the page table walker.
// Depends on fptw_pkg for field widths.
interface fptw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [fptw_pkg::PA_W-1:0]    entry_addr;
  logic [fptw_pkg::ENTRY_W-1:0] entry_data;
  logic [fptw_pkg::VA_W-1:0]    virt_addr;

  modport source (output valid, op, entry_addr, entry_data, virt_addr, input ready);
  modport sink (input valid, op, entry_addr, entry_data, virt_addr, output ready);
endinterface

interface fptw_out_if;
  logic                      valid;
  logic                      ready;
  logic [fptw_pkg::PA_W-1:0] phys_addr;
  logic                      fault;

  modport source (output valid, phys_addr, fault, input ready);
  modport sink (input valid, phys_addr, fault, output ready);
endinterface

// ===== src/fptw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/fptw_ctrl.sv =====
// Walk controller: clear sweep, item intake and one state per table level.
// Depends on fptw_pkg; drives the datapath through dp_cmd_t.
module fptw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  fptw_pkg::dp_status_t status,
  output fptw_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_L4    = 6'b000100,
    ST_L3    = 6'b001000,
    ST_L2    = 6'b010000,
    ST_L1    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    req_ready     = 1'b0;
    cmd           = '0;
    cmd.lvl       = fptw_pkg::LVL_4;
    cmd.res_kind  = fptw_pkg::RES_ZERO;
    unique case (state)
      ST_CLEAR: begin
        cmd.mem_we  = 1'b1;
        cmd.clr_sel = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = !status.out_busy;
        if (req_valid && !status.out_busy) begin
          if (status.req_op == fptw_pkg::OP_WRITE) begin
            cmd.mem_we   = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_kind = fptw_pkg::RES_ZERO;
          end else begin
            cmd.mem_re    = 1'b1;
            cmd.from_root = 1'b1;
            cmd.lvl       = fptw_pkg::LVL_4;
            cmd.load_item = 1'b1;
            state_next    = ST_L4;
          end
        end
      end
      ST_L4: begin
        if (!status.present) begin
          if (!status.out_busy) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = fptw_pkg::RES_FAULT;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.mem_re = 1'b1;
          cmd.lvl    = fptw_pkg::LVL_3;
          state_next = ST_L3;
        end
      end
      ST_L3: begin
        if (!status.present || status.page_size) begin
          if (!status.out_busy) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = status.present ? fptw_pkg::RES_1G : fptw_pkg::RES_FAULT;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.mem_re = 1'b1;
          cmd.lvl    = fptw_pkg::LVL_2;
          state_next = ST_L2;
        end
      end
      ST_L2: begin
        if (!status.present || status.page_size) begin
          if (!status.out_busy) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = status.present ? fptw_pkg::RES_2M : fptw_pkg::RES_FAULT;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.mem_re = 1'b1;
          cmd.lvl    = fptw_pkg::LVL_1;
          state_next = ST_L1;
        end
      end
      ST_L1: begin
        // large bit means nothing at the leaf level
        if (!status.out_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = status.present ? fptw_pkg::RES_4K : fptw_pkg::RES_FAULT;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/fptw_dp.sv =====
// Walk datapath: table memory, root register, address build and result register.
// Depends on fptw_pkg and fptw_ram; steered by fptw_ctrl through dp_cmd_t.
module fptw_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [fptw_pkg::PA_W-1:0]    cfg_wdata,
  input  logic                         req_op,
  input  logic [fptw_pkg::PA_W-1:0]    req_entry_addr,
  input  logic [fptw_pkg::ENTRY_W-1:0] req_entry_data,
  input  logic [fptw_pkg::VA_W-1:0]    req_virt_addr,
  input  logic                         rsp_ready,
  output logic                         rsp_valid,
  output logic [fptw_pkg::PA_W-1:0]    rsp_phys_addr,
  output logic                         rsp_fault,
  input  fptw_pkg::dp_cmd_t            cmd,
  output fptw_pkg::dp_status_t         status
);

  localparam int WALK_W = fptw_pkg::PA_W - fptw_pkg::PAGE_SH + fptw_pkg::IDX_W;

  logic [fptw_pkg::PA_W-1:0]    root_base;
  logic [fptw_pkg::VA_W-1:0]    va_q;
  logic [fptw_pkg::MEM_AW-1:0]  clr_cnt;
  logic [fptw_pkg::ENTRY_W-1:0] rd_data;

  logic [fptw_pkg::VA_W-1:0]    va_sel;
  logic [fptw_pkg::PA_W-1:0]    base_sel;
  logic [fptw_pkg::IDX_W-1:0]   idx;
  logic [WALK_W-1:0]            walk_word;
  logic [fptw_pkg::MEM_AW-1:0]  raddr;
  logic [fptw_pkg::MEM_AW-1:0]  waddr;
  logic [fptw_pkg::ENTRY_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_base <= '0;
    end else if (cfg_we) begin
      root_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.mem_we && cmd.clr_sel) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      va_q <= req_virt_addr;
    end
  end

  // next table base comes from the entry just read, the first one from the root
  assign va_sel   = cmd.from_root ? req_virt_addr : va_q;
  assign base_sel = cmd.from_root ? root_base : rd_data[fptw_pkg::PA_W-1:0];

  always_comb begin
    unique case (cmd.lvl)
      fptw_pkg::LVL_4: idx = va_sel[47:39];
      fptw_pkg::LVL_3: idx = va_sel[38:30];
      fptw_pkg::LVL_2: idx = va_sel[29:21];
      fptw_pkg::LVL_1: idx = va_sel[20:12];
      default:         idx = va_sel[20:12];
    endcase
  end

  // word index wraps modulo the table depth
  assign walk_word = {base_sel[fptw_pkg::PA_W-1:fptw_pkg::PAGE_SH], idx};
  assign raddr     = walk_word[fptw_pkg::MEM_AW-1:0];
  assign waddr     = cmd.clr_sel ? clr_cnt : req_entry_addr[fptw_pkg::MEM_AW+2:3];
  assign wdata     = cmd.clr_sel ? '0 : req_entry_data;

  fptw_ram #(
    .WIDTH (fptw_pkg::ENTRY_W),
    .DEPTH (fptw_pkg::TABLE_WORDS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.mem_re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        fptw_pkg::RES_ZERO: begin
          rsp_phys_addr <= '0;
          rsp_fault     <= 1'b0;
        end
        fptw_pkg::RES_FAULT: begin
          rsp_phys_addr <= '0;
          rsp_fault     <= 1'b1;
        end
        fptw_pkg::RES_1G: begin
          rsp_phys_addr <= {rd_data[51:30], va_q[29:0]};
          rsp_fault     <= 1'b0;
        end
        fptw_pkg::RES_2M: begin
          rsp_phys_addr <= {rd_data[51:21], va_q[20:0]};
          rsp_fault     <= 1'b0;
        end
        fptw_pkg::RES_4K: begin
          rsp_phys_addr <= {rd_data[51:12], va_q[11:0]};
          rsp_fault     <= 1'b0;
        end
        default: begin
          rsp_phys_addr <= '0;
          rsp_fault     <= 1'b0;
        end
      endcase
    end
  end

  assign status.present   = rd_data[fptw_pkg::ENT_PRESENT];
  assign status.page_size = rd_data[fptw_pkg::ENT_LARGE];
  assign status.out_busy  = rsp_valid && !rsp_ready;
  assign status.clr_last  = &clr_cnt;
  assign status.req_op    = req_op;

endmodule

// ===== src/four_level_page_table_walker.sv =====
// Four-level page table walker with an internal 4096 x 64-bit table memory.
// Channels: req (sink) carries op, entry_addr, entry_data, virt_addr; rsp
// (source) carries phys_addr and fault. One rsp item per req item, in order.
// cfg_we/cfg_wdata load root_base; write it only while no item is in flight.
// A write item stores one entry; its registered result (zero, no fault) is valid
// the cycle after acceptance; writes may follow every cycle unless rsp stalls.
// A translate item reads one table entry per level from the single RAM read
// port, which has a registered read; it stops on a fault, a 1 GiB page (L3),
// a 2 MiB page (L2) or at L1 with a 4 KiB page. No item is taken during a
// walk; the next can be taken in the cycle its result is valid if rsp is ready.
// Reset clears root_base and sweeps the table to zero, one entry per cycle:
// req stays not ready until every entry has been cleared.
// When rsp stalls, a finished result waits in the output register; a walk
// that completes behind it holds its last entry until the register frees.
// Depends on fptw_pkg, fptw_if, fptw_ram, fptw_ctrl and fptw_dp.
module four_level_page_table_walker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [fptw_pkg::PA_W-1:0] cfg_wdata,
  fptw_in_if.sink                   req,
  fptw_out_if.source                rsp
);

  fptw_pkg::dp_cmd_t    cmd;
  fptw_pkg::dp_status_t status;

  fptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fptw_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .req_op         (req.op),
    .req_entry_addr (req.entry_addr),
    .req_entry_data (req.entry_data),
    .req_virt_addr  (req.virt_addr),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_phys_addr  (rsp.phys_addr),
    .rsp_fault      (rsp.fault),
    .cmd            (cmd),
    .status         (status)
  );

`ifndef SYNTHESIS
  a_walk_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.op == fptw_pkg::OP_TRANSLATE) |=> !req.ready)
    else $error("intake open during a walk");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.op == fptw_pkg::OP_WRITE)
      |=> (rsp.valid && rsp.phys_addr == '0 && !rsp.fault))
    else $error("write item result missing or nonzero");

  a_fault_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.fault) |-> (rsp.phys_addr == '0))
    else $error("fault with nonzero address");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !status.out_busy)
    else $error("pending result overwritten");
`endif

endmodule
